/* rtl/clr_pkg.sv */
// Shared constants, types and arithmetic helpers of the chain length relaxation block.
// Used by the channel interfaces, the store, the shared unit and the top level.
package clr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 32;
  localparam int REST_W     = 31;
  localparam int ITER_W     = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SINGLE_NODE = 3'd0,
    REG_NODE_SELECT = 3'd1,
    REG_STEP_SIZE   = 3'd2,
    REG_TOLERANCE   = 3'd3,
    REG_ANCHOR_WGT  = 3'd4,
    REG_ITER_LIMIT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             we_pos;
    logic             we_ref;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] rest_raddr;
  } st_req_t;

  typedef struct packed {
    logic start;
    logic root;
  } unit_req_t;

  function automatic logic signed [31:0] sat32_33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat32_40(input logic signed [39:0] v);
    if ((v[39:31] != 9'h000) && (v[39:31] != 9'h1FF)) begin
      return v[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Product scaled down by 2^16, truncated toward zero.
  function automatic logic signed [47:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return t[63:16];
  endfunction

endpackage

/* rtl/clr_if.sv */
// Channel interfaces of the chain length relaxation block: points in, results out,
// register writes. Depends on clr_pkg.
interface clr_in_if import clr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;
  logic [REST_W-1:0]         rest_length;
  logic                      last_point;
  modport source (output valid, cur_x, cur_y, ref_x, ref_y, rest_length, last_point,
                  input ready);
  modport sink (input valid, cur_x, cur_y, ref_x, ref_y, rest_length, last_point,
                output ready);
endinterface

interface clr_out_if import clr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] new_x;
  logic signed [COORD_W-1:0] new_y;
  logic                      converged;
  logic [ITER_W-1:0]         iterations_used;
  logic                      zero_length_seen;
  logic                      last_result;
  modport source (output valid, point_index, new_x, new_y, converged, iterations_used,
                  zero_length_seen, last_result, input ready);
  modport sink (input valid, point_index, new_x, new_y, converged, iterations_used,
                zero_length_seen, last_result, output ready);
endinterface

interface clr_cfg_if import clr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/clr_store.sv */
// Point stores: position, anchor and rest length memories with registered reads.
// Depends on clr_pkg.
module clr_store import clr_pkg::*; (
  input  logic                clk_i,
  input  st_req_t             req_i,
  input  logic [63:0]         wpos_i,
  input  logic [63:0]         wref_i,
  input  logic [REST_W-1:0]   wrest_i,
  output logic [63:0]         rpos_o,
  output logic [63:0]         rref_o,
  output logic [REST_W-1:0]   rrest_o
);

  logic [63:0]       pos_mem [MAX_POINTS];
  logic [63:0]       ref_mem [MAX_POINTS];
  logic [REST_W-1:0] rest_mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (req_i.we_pos) begin
      pos_mem[req_i.waddr] <= wpos_i;
    end
    if (req_i.we_ref) begin
      ref_mem[req_i.waddr]  <= wref_i;
      rest_mem[req_i.waddr] <= wrest_i;
    end
    rpos_o  <= pos_mem[req_i.raddr];
    rref_o  <= ref_mem[req_i.raddr];
    rrest_o <= rest_mem[req_i.rest_raddr];
  end

endmodule

/* rtl/clr_unit.sv */
// Shared shift-subtract unit: 32-step integer square root or 32-bit quotient division.
// Depends on clr_pkg.
module clr_unit import clr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_req_t   req_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_q, root_q, done_q;
  logic [4:0]  cnt_q;
  logic [33:0] rem_q;
  logic [63:0] acc_q;
  logic [31:0] den_q, res_q;
  logic [35:0] w, s, wn;
  logic        ge;

  always_comb begin
    w  = root_q ? {rem_q, acc_q[63:62]} : {1'b0, rem_q, acc_q[63]};
    s  = root_q ? {2'b00, res_q, 2'b01} : {4'b0000, den_q};
    ge = (w >= s);
    wn = ge ? (w - s) : w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      root_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      acc_q  <= '0;
      den_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        root_q <= req_i.root;
        cnt_q  <= '0;
        den_q  <= den_i;
        res_q  <= '0;
        if (req_i.root) begin
          rem_q <= '0;
          acc_q <= num_i;
        end else begin
          rem_q <= {2'b00, num_i[63:32]};
          acc_q <= {num_i[31:0], 32'h0};
        end
      end else if (busy_q) begin
        rem_q <= wn[33:0];
        res_q <= {res_q[30:0], ge};
        acc_q <= root_q ? {acc_q[61:0], 2'b00} : {acc_q[62:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* rtl/chain_length_relaxation.sv */
// Chain length relaxation block: point loading, descent sequencer and result emission.
// Depends on clr_pkg, clr_if, clr_store and clr_unit.
//
// Points arrive on in_i, one transaction per point; in_i is not ready while the
// position of a stored point is written. The point with last_point set starts
// steepest-descent relaxation of the stored polyline, unless the iteration limit
// is zero; in_i is not ready until every point has been handed to out_o. Each
// segment term uses two 32-step divisions and one 32-step square root in the shared
// shift-subtract unit; a zero-length segment skips the divisions. Each segment term
// is followed by an anchor pull, skipped in single node mode, and each node takes a
// read, a move and a norm update. Node 1 takes two segment terms, other interior
// nodes one; each iteration adds a setup and a stop test. Results then leave one
// transaction per point; a stalled receiver holds the output register and the
// block waits. cfg_i is always ready; it must be written only while the block is
// idle, a rule for the user that the block does not enforce. Reset clears the
// control state and restores the register defaults; the stores are not cleared.
module chain_length_relaxation import clr_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  clr_in_if.sink       in_i,
  clr_out_if.source    out_o,
  clr_cfg_if.sink      cfg_i
);

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001, S_ITER = 24'h000002, S_RDN  = 24'h000004,
    S_RDM   = 24'h000008, S_DIF  = 24'h000010, S_SQX  = 24'h000020,
    S_SQY   = 24'h000040, S_SQS  = 24'h000080, S_SQW  = 24'h000100,
    S_MUL   = 24'h000200, S_DIV  = 24'h000400, S_DVW  = 24'h000800,
    S_ANX   = 24'h001000, S_ANY  = 24'h002000, S_ANE  = 24'h004000,
    S_MVX   = 24'h008000, S_MVY  = 24'h010000, S_MVW  = 24'h020000,
    S_NY    = 24'h040000, S_NZ   = 24'h080000, S_CHECK = 24'h100000,
    S_ERD   = 24'h200000, S_EOUT = 24'h400000, S_NEXT = 24'h800000
  } state_e;

  state_e state_q, state_d;

  logic              single_q;
  logic [IDX_W-1:0]  nsel_q;
  logic [15:0]       step_q, tol_q, wgt_q;
  logic [ITER_W-1:0] limit_q;

  logic [CNT_W-1:0]  count_q, count_d, size_q, size_d, k_q, k_d;
  logic [IDX_W-1:0]  node_q, node_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [63:0]       norm_q, norm_d, sq_q, sq_d;
  logic              zlf_q, zlf_d, conv_q, conv_d, first_q, first_d;
  logic              cap_q, cap_d, yax_q, yax_d, neg_q, neg_d;
  logic signed [31:0] pnx_q, pnx_d, pny_q, pny_d, ax_q, ax_d, ay_q, ay_d;
  logic signed [31:0] dx_q, dx_d, dy_q, dy_d, gxs_q, gxs_d, gys_q, gys_d;
  logic signed [39:0] gx_q, gx_d, gy_q, gy_d;
  logic [REST_W-1:0]  len_q, len_d;
  logic [31:0]        l_q, l_d;
  logic signed [63:0] prod_q, prod_d;

  logic              oval_q, out_load;
  logic [IDX_W-1:0]  oidx_q;
  logic signed [31:0] ox_q, oy_q;
  logic              oconv_q, ozl_q, olast_q;
  logic [ITER_W-1:0] oiter_q;

  st_req_t            st_req;
  unit_req_t          u_req;
  logic [63:0]        rpos, rref, u_num;
  logic [REST_W-1:0]  rrest;
  logic               u_done;
  logic [31:0]        u_res, thr;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] rd_x, rd_y, adx, ady, new_y;
  logic signed [47:0] mq;
  logic signed [32:0] qs;
  logic [64:0]        nsum;
  logic [63:0]        nsat;
  logic [ITER_W-1:0]  iter_inc;

  clr_store u_store (
    .clk_i   (clk_i),
    .req_i   (st_req),
    .wpos_i  ({pny_q, pnx_q}),
    .wref_i  ({in_i.ref_y, in_i.ref_x}),
    .wrest_i (in_i.rest_length),
    .rpos_o  (rpos),
    .rref_o  (rref),
    .rrest_o (rrest)
  );

  clr_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .num_i  (u_num),
    .den_i  (l_q),
    .done_o (u_done),
    .res_o  (u_res)
  );

  assign rd_x     = rpos[31:0];
  assign rd_y     = rpos[63:32];
  assign adx      = sat32_33(33'(pnx_q) - 33'(ax_q));
  assign ady      = sat32_33(33'(pny_q) - 33'(ay_q));
  assign mq       = mulq(prod_q);
  assign qs       = neg_q ? -$signed({1'b0, u_res}) : $signed({1'b0, u_res});
  assign nsum     = {1'b0, norm_q} + {1'b0, prod_q};
  assign nsat     = nsum[64] ? '1 : nsum[63:0];
  assign thr      = tol_q * tol_q;
  assign iter_inc = iter_q + ITER_W'(1);
  assign new_y    = sat32_33(33'(pny_q) - 33'(mq));
  assign mul_p    = mul_a * mul_b;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    size_d   = size_q;
    k_d      = k_q;
    node_d   = node_q;
    iter_d   = iter_q;
    norm_d   = norm_q;
    sq_d     = sq_q;
    zlf_d    = zlf_q;
    conv_d   = conv_q;
    first_d  = first_q;
    cap_d    = cap_q;
    yax_d    = yax_q;
    neg_d    = neg_q;
    pnx_d    = pnx_q;
    pny_d    = pny_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    gxs_d    = gxs_q;
    gys_d    = gys_q;
    gx_d     = gx_q;
    gy_d     = gy_q;
    len_d    = len_q;
    l_d      = l_q;
    mul_a    = '0;
    mul_b    = '0;
    prod_d   = prod_q;
    st_req   = '0;
    u_req    = '0;
    u_num    = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    out_load = 1'b0;
    in_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          pnx_d = in_i.cur_x;
          pny_d = in_i.cur_y;
          if (count_q < CNT_W'(MAX_POINTS)) begin
            st_req.we_ref = 1'b1;
            st_req.waddr  = count_q[IDX_W-1:0];
            count_d       = count_q + CNT_W'(1);
            state_d       = S_NEXT;
          end
          if (in_i.last_point) begin
            size_d = (count_q < CNT_W'(MAX_POINTS)) ? count_q + CNT_W'(1) : count_q;
            iter_d = '0;
            zlf_d  = 1'b0;
            conv_d = 1'b0;
            k_d    = '0;
            if (count_q >= CNT_W'(MAX_POINTS)) begin
              state_d = (limit_q == '0) ? S_ERD : S_ITER;
            end
          end
          if (!in_i.last_point && (count_q >= CNT_W'(MAX_POINTS))) begin
            state_d = S_IDLE;
          end
          yax_d = in_i.last_point;
        end
      end
      S_NEXT: begin
        // The position write follows the reference write of the same point.
        st_req.we_pos = 1'b1;
        st_req.waddr  = IDX_W'(count_q - CNT_W'(1));
        state_d       = yax_q ? ((limit_q == '0) ? S_ERD : S_ITER) : S_IDLE;
        if (!yax_q) begin
          state_d = S_IDLE;
        end
      end
      S_ITER: begin
        norm_d = '0;
        if (single_q) begin
          node_d = nsel_q;
          if ((nsel_q != '0) && ({1'b0, nsel_q} + CNT_W'(1) < size_q)) begin
            state_d = S_RDN;
          end else begin
            state_d = S_CHECK;
          end
        end else begin
          node_d  = IDX_W'(1);
          state_d = (size_q >= CNT_W'(3)) ? S_RDN : S_CHECK;
        end
      end
      S_RDN: begin
        st_req.raddr = node_q;
        gx_d    = '0;
        gy_d    = '0;
        first_d = (node_q == IDX_W'(1));
        cap_d   = 1'b1;
        state_d = S_RDM;
      end
      S_RDM: begin
        if (cap_q) begin
          pnx_d = rd_x;
          pny_d = rd_y;
          ax_d  = rref[31:0];
          ay_d  = rref[63:32];
          cap_d = 1'b0;
        end
        st_req.raddr      = first_q ? '0 : node_q + IDX_W'(1);
        st_req.rest_raddr = first_q ? '0 : node_q;
        state_d = S_DIF;
      end
      S_DIF: begin
        dx_d    = sat32_33(33'(pnx_q) - 33'(rd_x));
        dy_d    = sat32_33(33'(pny_q) - 33'(rd_y));
        len_d   = rrest;
        state_d = S_SQX;
      end
      S_SQX: begin
        mul_a   = 33'(dx_q);
        mul_b   = 33'(dx_q);
        prod_d  = mul_p[63:0];
        gx_d    = gx_q + (40'(dx_q) <<< 1);
        gy_d    = gy_q + (40'(dy_q) <<< 1);
        state_d = S_SQY;
      end
      S_SQY: begin
        sq_d    = prod_q;
        mul_a   = 33'(dy_q);
        mul_b   = 33'(dy_q);
        prod_d  = mul_p[63:0];
        state_d = S_SQS;
      end
      S_SQS: begin
        u_req.start = 1'b1;
        u_req.root  = 1'b1;
        u_num       = sq_q + prod_q;
        state_d     = S_SQW;
      end
      S_SQW: begin
        if (u_done) begin
          l_d   = u_res;
          yax_d = 1'b0;
          if (u_res == '0) begin
            zlf_d   = 1'b1;
            state_d = single_q ? (first_q ? S_RDM : S_MVX) : S_ANX;
            if (single_q && first_q) begin
              first_d = 1'b0;
            end
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        mul_a   = $signed({2'b00, len_q});
        mul_b   = yax_q ? 33'(dy_q) : 33'(dx_q);
        prod_d  = mul_p[63:0];
        state_d = S_DIV;
      end
      S_DIV: begin
        u_req.start = 1'b1;
        neg_d       = prod_q[63];
        state_d     = S_DVW;
      end
      S_DVW: begin
        if (u_done) begin
          if (!yax_q) begin
            gx_d    = gx_q - (40'(qs) <<< 1);
            yax_d   = 1'b1;
            state_d = S_MUL;
          end else begin
            gy_d    = gy_q - (40'(qs) <<< 1);
            state_d = single_q ? (first_q ? S_RDM : S_MVX) : S_ANX;
            if (single_q && first_q) begin
              first_d = 1'b0;
            end
          end
        end
      end
      S_ANX: begin
        mul_a   = $signed({17'b0, wgt_q});
        mul_b   = 33'(adx);
        prod_d  = mul_p[63:0];
        state_d = S_ANY;
      end
      S_ANY: begin
        gx_d    = gx_q + (40'(mq) <<< 1);
        mul_a   = $signed({17'b0, wgt_q});
        mul_b   = 33'(ady);
        prod_d  = mul_p[63:0];
        state_d = S_ANE;
      end
      S_ANE: begin
        gy_d    = gy_q + (40'(mq) <<< 1);
        first_d = 1'b0;
        state_d = first_q ? S_RDM : S_MVX;
      end
      S_MVX: begin
        gxs_d   = sat32_40(gx_q);
        gys_d   = sat32_40(gy_q);
        mul_a   = $signed({17'b0, step_q});
        mul_b   = 33'(sat32_40(gx_q));
        prod_d  = mul_p[63:0];
        state_d = S_MVY;
      end
      S_MVY: begin
        pnx_d   = sat32_33(33'(pnx_q) - 33'(mq));
        mul_a   = $signed({17'b0, step_q});
        mul_b   = 33'(gys_q);
        prod_d  = mul_p[63:0];
        state_d = S_MVW;
      end
      S_MVW: begin
        pny_d         = new_y;
        mul_a         = 33'(gxs_q);
        mul_b         = 33'(gxs_q);
        prod_d        = mul_p[63:0];
        state_d       = S_NY;
      end
      S_NY: begin
        st_req.we_pos = 1'b1;
        st_req.waddr  = node_q;
        norm_d        = nsat;
        mul_a         = 33'(gys_q);
        mul_b         = 33'(gys_q);
        prod_d        = mul_p[63:0];
        state_d       = S_NZ;
      end
      S_NZ: begin
        norm_d = nsat;
        if (!single_q && ({1'b0, node_q} + CNT_W'(2) < size_q)) begin
          node_d  = node_q + IDX_W'(1);
          state_d = S_RDN;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        iter_d = iter_inc;
        if (norm_q < {32'h0, thr}) begin
          conv_d  = 1'b1;
          state_d = S_ERD;
        end else if (iter_inc >= limit_q) begin
          state_d = S_ERD;
        end else begin
          state_d = S_ITER;
        end
      end
      S_ERD: begin
        st_req.raddr = k_q[IDX_W-1:0];
        state_d      = S_EOUT;
      end
      S_EOUT: begin
        st_req.raddr = k_q[IDX_W-1:0];
        if (!oval_q || out_o.ready) begin
          out_load = 1'b1;
          if (k_q + CNT_W'(1) == size_q) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= 1'b0;
      nsel_q   <= IDX_W'(1);
      step_q   <= 16'd3277;
      tol_q    <= 16'd655;
      wgt_q    <= 16'd66;
      limit_q  <= ITER_W'(10000);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SINGLE_NODE: single_q <= cfg_i.data[0];
        REG_NODE_SELECT: nsel_q   <= cfg_i.data[IDX_W-1:0];
        REG_STEP_SIZE:   step_q   <= cfg_i.data;
        REG_TOLERANCE:   tol_q    <= cfg_i.data;
        REG_ANCHOR_WGT:  wgt_q    <= cfg_i.data;
        REG_ITER_LIMIT:  limit_q  <= cfg_i.data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      size_q  <= '0;
      k_q     <= '0;
      node_q  <= '0;
      iter_q  <= '0;
      norm_q  <= '0;
      zlf_q   <= 1'b0;
      conv_q  <= 1'b0;
      first_q <= 1'b0;
      cap_q   <= 1'b0;
      yax_q   <= 1'b0;
      neg_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      size_q  <= size_d;
      k_q     <= k_d;
      node_q  <= node_d;
      iter_q  <= iter_d;
      norm_q  <= norm_d;
      zlf_q   <= zlf_d;
      conv_q  <= conv_d;
      first_q <= first_d;
      cap_q   <= cap_d;
      yax_q   <= yax_d;
      neg_q   <= neg_d;
      if (out_load) begin
        oval_q <= 1'b1;
      end else if (out_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pnx_q  <= pnx_d;
    pny_q  <= pny_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    gxs_q  <= gxs_d;
    gys_q  <= gys_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    len_q  <= len_d;
    l_q    <= l_d;
    sq_q   <= sq_d;
    prod_q <= prod_d;
    if (out_load) begin
      oidx_q  <= k_q[IDX_W-1:0];
      ox_q    <= rd_x;
      oy_q    <= rd_y;
      oconv_q <= conv_q;
      oiter_q <= iter_q;
      ozl_q   <= zlf_q;
      olast_q <= (k_q + CNT_W'(1) == size_q);
    end
  end

  assign out_o.valid            = oval_q;
  assign out_o.point_index      = oidx_q;
  assign out_o.new_x            = ox_q;
  assign out_o.new_y            = oy_q;
  assign out_o.converged        = oconv_q;
  assign out_o.iterations_used  = oiter_q;
  assign out_o.zero_length_seen = ozl_q;
  assign out_o.last_result      = olast_q;

endmodule

/* test/clr_tb_pkg.sv */
`timescale 1ns / 1ps
// Point record and phase settings shared by the chain relaxation testbench.
// Depends on clr_pkg.
package clr_tb_pkg;
  import clr_pkg::*;

  typedef struct {
    int          cx;
    int          cy;
    int          rx;
    int          ry;
    int unsigned rest;
    bit          last;
  } point_t;

  typedef struct {
    bit          mode;
    int unsigned sel;
    int unsigned step;
    int unsigned tol;
    int unsigned wgt;
    int unsigned lim;
  } relax_cfg_t;

  typedef struct {
    bit [IDX_W-1:0]  idx;
    int              x;
    int              y;
    bit              conv;
    bit [ITER_W-1:0] iters;
    bit              zero;
    bit              last;
  } node_out_t;
endpackage

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of chain_length_relaxation: directed polylines, register
// extremes, a full store and random polylines under random idling on both channels.
// Depends on clr_pkg, clr_if, clr_tb_pkg and chain_length_relaxation.
module testbench;
  import clr_pkg::*;
  import clr_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  clr_in_if  in_if ();
  clr_out_if out_if ();
  clr_cfg_if cfg_if ();

  chain_length_relaxation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  int          pos_x[MAX_POINTS];
  int          pos_y[MAX_POINTS];
  int          anc_x[MAX_POINTS];
  int          anc_y[MAX_POINTS];
  int unsigned rest_len[MAX_POINTS];
  int unsigned n_loaded;
  relax_cfg_t  cur_cfg;
  bit          zero_seen;
  int unsigned iters_done;
  bit          conv_last;
  node_out_t   pending_nodes[$];

  int errors;
  int n_points;
  int n_results;
  int n_chains;
  int stall_left;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void segment_pull(input int n, input int m, input int unsigned len,
                                       inout longint gx, inout longint gy);
    longint dx;
    longint dy;
    longint l;
    dx = sat32(longint'(pos_x[n]) - pos_x[m]);
    dy = sat32(longint'(pos_y[n]) - pos_y[m]);
    l = longint'(isqrt(longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy))));
    gx += 2 * dx;
    gy += 2 * dy;
    if (l == 0) begin
      zero_seen = 1'b1;
    end else begin
      gx -= 2 * ((longint'(len) * dx) / l);
      gy -= 2 * ((longint'(len) * dy) / l);
    end
  endfunction

  function automatic void anchor_pull(input int n, inout longint gx, inout longint gy);
    longint dx;
    longint dy;
    dx = sat32(longint'(pos_x[n]) - anc_x[n]);
    dy = sat32(longint'(pos_y[n]) - anc_y[n]);
    gx += 2 * ((longint'(cur_cfg.wgt) * dx) / 65536);
    gy += 2 * ((longint'(cur_cfg.wgt) * dy) / 65536);
  endfunction

  function automatic longint unsigned sq_add(input longint unsigned acc, input longint g);
    longint unsigned s;
    s = acc + longint'(unsigned'(g * g));
    return (s < acc) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
  endfunction

  function automatic longint unsigned descend_node(input int n, input int size,
                                                   input bit anchors,
                                                   input longint unsigned norm);
    longint gx;
    longint gy;
    gx = 0;
    gy = 0;
    if (n > 0 && n + 1 < size) begin
      if (n == 1) begin
        segment_pull(1, 0, rest_len[0], gx, gy);
        if (anchors) anchor_pull(1, gx, gy);
      end
      segment_pull(n, n + 1, rest_len[n], gx, gy);
      if (anchors) anchor_pull(n, gx, gy);
    end
    gx = sat32(gx);
    gy = sat32(gy);
    pos_x[n] = int'(sat32(longint'(pos_x[n]) - (longint'(cur_cfg.step) * gx) / 65536));
    pos_y[n] = int'(sat32(longint'(pos_y[n]) - (longint'(cur_cfg.step) * gy) / 65536));
    return sq_add(sq_add(norm, gx), gy);
  endfunction

  function automatic bit relax_chain(input int size);
    longint unsigned thr;
    longint unsigned norm;
    thr = longint'(cur_cfg.tol) * cur_cfg.tol;
    zero_seen = 1'b0;
    iters_done = 0;
    for (int it = 0; it < cur_cfg.lim; it++) begin
      norm = 0;
      if (cur_cfg.mode) begin
        if (cur_cfg.sel < size) norm = descend_node(cur_cfg.sel, size, 1'b0, norm);
      end else begin
        for (int j = 0; j < size; j++) norm = descend_node(j, size, 1'b1, norm);
      end
      iters_done++;
      if (norm < thr) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_point(input point_t p);
    node_out_t o;
    int size;
    if (n_loaded < MAX_POINTS) begin
      pos_x[n_loaded] = p.cx;
      pos_y[n_loaded] = p.cy;
      anc_x[n_loaded] = p.rx;
      anc_y[n_loaded] = p.ry;
      rest_len[n_loaded] = p.rest & 32'h7FFF_FFFF;
      n_loaded++;
    end
    if (!p.last) return;
    size = n_loaded;
    conv_last = relax_chain(size);
    for (int k = 0; k < size; k++) begin
      o.idx = k[IDX_W-1:0];
      o.x = pos_x[k];
      o.y = pos_y[k];
      o.conv = conv_last;
      o.iters = iters_done[ITER_W-1:0];
      o.zero = zero_seen;
      o.last = (k == size - 1);
      pending_nodes.push_back(o);
    end
    n_loaded = 0;
    n_chains++;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_point(input point_t p);
    int gap;
    in_if.valid <= 1'b1;
    in_if.cur_x <= p.cx;
    in_if.cur_y <= p.cy;
    in_if.ref_x <= p.rx;
    in_if.ref_y <= p.ry;
    in_if.rest_length <= p.rest[REST_W-1:0];
    in_if.last_point <= p.last;
    do @(posedge clk_i); while (!in_if.ready);
    take_point(p);
    n_points++;
    gap = p.last ? 1 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_nodes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input relax_cfg_t c);
    drain();
    write_reg(REG_SINGLE_NODE, c.mode);
    write_reg(REG_NODE_SELECT, c.sel);
    write_reg(REG_STEP_SIZE, c.step);
    write_reg(REG_TOLERANCE, c.tol);
    write_reg(REG_ANCHOR_WGT, c.wgt);
    write_reg(REG_ITER_LIMIT, c.lim);
    cur_cfg = c;
  endtask

  function automatic point_t rand_point(input bit wide, input bit last);
    point_t p;
    if (wide) begin
      p.cx = $urandom;
      p.cy = $urandom;
      p.rx = $urandom;
      p.ry = $urandom;
      p.rest = $urandom & 32'h7FFF_FFFF;
    end else begin
      p.cx = int'($urandom_range(0, 40 << 16)) - (20 << 16);
      p.cy = int'($urandom_range(0, 40 << 16)) - (20 << 16);
      p.rx = p.cx + int'($urandom_range(0, 4 << 16)) - (2 << 16);
      p.ry = p.cy + int'($urandom_range(0, 4 << 16)) - (2 << 16);
      p.rest = $urandom_range(0, 8 << 16);
    end
    p.last = last;
    return p;
  endfunction

  always @(posedge clk_i) begin
    node_out_t w;
    if (out_if.valid && out_if.ready) begin
      n_results++;
      if (pending_nodes.size() == 0) begin
        report("unexpected transaction, point_index", out_if.point_index, -1);
      end else begin
        w = pending_nodes.pop_front();
        if (out_if.point_index !== w.idx) report("point_index", out_if.point_index, w.idx);
        if (out_if.new_x !== w.x) report("new_x", out_if.new_x, w.x);
        if (out_if.new_y !== w.y) report("new_y", out_if.new_y, w.y);
        if (out_if.converged !== w.conv) report("converged", out_if.converged, w.conv);
        if (out_if.iterations_used !== w.iters)
          report("iterations_used", out_if.iterations_used, w.iters);
        if (out_if.zero_length_seen !== w.zero)
          report("zero_length_seen", out_if.zero_length_seen, w.zero);
        if (out_if.last_result !== w.last)
          report("last_result", out_if.last_result, w.last);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if ((n_chains / 4) % 3 == 1) begin
      out_if.ready <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_if.ready <= 1'b1;
    end
  end

  typedef struct {
    int     ph;
    point_t p;
    bit     chk;
    bit     conv;
    int     iters;
    int     zero;
  } drow_t;

  relax_cfg_t phases[6];
  drow_t      rows[$];

  function automatic point_t pt(input int cx, input int cy, input int rx, input int ry,
                                input int unsigned rest, input bit last);
    point_t p;
    p.cx = cx;
    p.cy = cy;
    p.rx = rx;
    p.ry = ry;
    p.rest = rest;
    p.last = last;
    return p;
  endfunction

  function automatic void add_row(input int ph, input point_t p, input bit chk,
                                  input bit conv, input int iters, input int zero);
    drow_t r;
    r.ph = ph;
    r.p = p;
    r.chk = chk;
    r.conv = conv;
    r.iters = iters;
    r.zero = zero;
    rows.push_back(r);
  endfunction

  initial begin
    int cur_ph;
    relax_cfg_t c;
    point_t p;
    int len;
    int sent;
    bit wide;

    in_if.valid = 1'b0;
    in_if.cur_x = '0;
    in_if.cur_y = '0;
    in_if.ref_x = '0;
    in_if.ref_y = '0;
    in_if.rest_length = '0;
    in_if.last_point = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SINGLE_NODE;
    cfg_if.data = '0;
    errors = 0;
    n_points = 0;
    n_results = 0;
    n_chains = 0;
    stall_left = 0;
    n_loaded = 0;
    cur_cfg = '{1'b0, 1, 3277, 655, 66, 10000};

    phases[0] = cur_cfg;
    phases[1] = '{1'b0, 0, 3277, 655, 66, 0};
    phases[2] = '{1'b0, 5, 65535, 0, 65535, 3};
    phases[3] = '{1'b1, 2, 0, 0, 0, 4};
    phases[4] = '{1'b1, 63, 65535, 65535, 0, 16383};
    phases[5] = '{1'b0, 1, 0, 0, 1000, 2};

    // Lone point and two-point line: no interior node, stop after one pass.
    add_row(0, pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1), 1, 1, 1, 0);
    add_row(0, pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0),
            0, 0, 0, 0);
    add_row(0, pt(0, 0, 0, 0, 0, 1), 1, 1, 1, 0);
    // Coincident points on their anchors: zero-length segments, no pull.
    for (int i = 0; i < 3; i++)
      add_row(0, pt(5 << 16, -3 << 16, 5 << 16, -3 << 16, 1 << 16, i == 2), i == 2, 1, 1, 1);
    for (int i = 0; i < 4; i++)
      add_row(1, pt(i << 16, i << 15, 0, 0, 1 << 16, i == 3), i == 3, 0, 0, 0);
    add_row(2, pt(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0), 0, 0, 0, 0);
    add_row(2, pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0), 0, 0, 0, 0);
    add_row(2, pt(3 << 16, 1 << 16, 0, 32'h8000_0000, 2 << 16, 0), 0, 0, 0, 0);
    add_row(2, pt(0, 0, 0, 0, 0, 1), 1, 0, 3, -1);
    for (int i = 0; i < 5; i++)
      add_row(3, pt(i << 17, (i * i) << 14, 0, 0, 3 << 16, i == 4), i == 4, 0, 4, 0);
    for (int i = 0; i < 3; i++)
      add_row(4, pt(-i << 16, i << 16, 0, 0, 1 << 16, i == 2), i == 2, 1, 1, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_ph = 0;
    foreach (rows[i]) begin
      if (rows[i].ph != cur_ph) begin
        cur_ph = rows[i].ph;
        apply_cfg(phases[cur_ph]);
      end
      send_point(rows[i].p);
      if (rows[i].chk) begin
        if (conv_last != rows[i].conv) report("directed converged", conv_last, rows[i].conv);
        if (iters_done != rows[i].iters)
          report("directed iterations", iters_done, rows[i].iters);
        if (rows[i].zero >= 0 && zero_seen != rows[i].zero)
          report("directed zero length", zero_seen, rows[i].zero);
      end
    end

    // Overfull store: points past the capacity are dropped, the last still starts.
    apply_cfg(phases[5]);
    for (int i = 0; i < MAX_POINTS + 2; i++) send_point(rand_point(i % 7 == 0, i == MAX_POINTS + 1));

    sent = 0;
    while (sent < 60) begin
      if (n_chains % 3 == 0) begin
        c.mode = ($urandom_range(0, 3) == 0);
        c.sel = $urandom_range(0, 11);
        c.step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8000);
        c.tol = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 65535);
        c.wgt = $urandom_range(0, 65535);
        c.lim = $urandom_range(1, 6);
        apply_cfg(c);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 8);
      wide = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        p = rand_point(wide || ($urandom_range(0, 19) == 0), i == len - 1);
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          p.cx = pos_x[n_loaded - 1];
          p.cy = pos_y[n_loaded - 1];
        end
        send_point(p);
        sent++;
      end
    end

    drain();
    $display("covered %0d points in %0d polylines, %0d results checked",
             n_points, n_chains, n_results);
    $display("register extremes, single node mode, zero-length segments and a full store");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", pending_nodes.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
